>>> rtl/cbr_pkg.sv
`default_nettype none
package cbr_pkg;

    // Default sizes of the storage.
    localparam int MAX_SUBCHANNELS_DEF = 32;
    localparam int MAX_WINDOW_DEF      = 1024;

    // Field widths of the stream beats.
    localparam int FUNC_W      = 2;
    localparam int SLOT_W      = 32;
    localparam int FIRST_W     = 5;
    localparam int SPAN_W      = 6;
    localparam int POWER_W     = 32;
    localparam int COUNT_OUT_W = 16;
    localparam int FRAC_W      = 16;
    localparam int RATIO_W     = FRAC_W + 1;
    localparam int S_DATA_W    = 80;
    localparam int M_DATA_W    = 40;

    // Configuration registers.
    localparam int WIN_REG_W   = 11;
    localparam int NSC_REG_W   = 6;
    localparam int THR_W       = 32;
    localparam int ADDR_W      = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [1:0] REG_WINDOW    = 2'd0;
    localparam logic [1:0] REG_SUBCH     = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    localparam logic [WIN_REG_W-1:0] WIN_RESET = 11'd100;
    localparam logic [NSC_REG_W-1:0] NSC_RESET = 6'd10;
    localparam logic [THR_W-1:0]     THR_RESET = 32'd1;

    // Command codes carried in the input tuser.
    localparam logic [FUNC_W-1:0] FUNC_ADD         = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE_MON   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE_UNMON = 2'd2;

    typedef enum logic [1:0] {
        ACC_ADD,
        ACC_COUNT,
        ACC_CLEAR
    } t_acc_op;

    typedef struct packed {
        logic    start;
        t_acc_op op;
    } t_acc_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_HIST,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

>>> rtl/cbr_acc.sv
`default_nettype none
module cbr_acc #(
    parameter int MAX_SUBCHANNELS = cbr_pkg::MAX_SUBCHANNELS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire cbr_pkg::t_acc_ctl               i_ctl,
    input  wire [$clog2(MAX_SUBCHANNELS+1)-1:0] i_start_idx,
    input  wire [$clog2(MAX_SUBCHANNELS+1)-1:0] i_end_idx,
    input  wire [cbr_pkg::POWER_W-1:0]           i_power,
    input  wire [cbr_pkg::THR_W-1:0]             i_threshold,
    output logic                                 o_done,
    output logic [$clog2(MAX_SUBCHANNELS+1)-1:0] o_busy
);

    localparam int SC_CW = $clog2(MAX_SUBCHANNELS + 1);
    localparam int SC_IW = (MAX_SUBCHANNELS > 1) ? $clog2(MAX_SUBCHANNELS) : 1;
    localparam int PW    = cbr_pkg::POWER_W;

    logic [PW-1:0]              r_mem [MAX_SUBCHANNELS];
    logic [MAX_SUBCHANNELS-1:0] r_vld;
    logic                       r_run;
    cbr_pkg::t_acc_op           r_op;
    logic [SC_CW-1:0]           r_idx;
    logic [SC_CW-1:0]           r_end;
    logic [PW-1:0]              r_power;
    logic                       r_p_vld;
    logic [SC_IW-1:0]           r_p_idx;
    logic [PW-1:0]              r_rdata;
    logic [SC_CW-1:0]           r_cnt;
    logic                       r_done;

    logic          issue;
    logic [PW-1:0] cur;
    logic [PW:0]   sum;
    logic [PW-1:0] sum_sat;

    always_comb begin
        issue   = r_run && (r_idx < r_end);
        // An entry not written since the last clear reads as zero.
        cur     = r_vld[r_p_idx] ? r_rdata : '0;
        sum     = {1'b0, cur} + {1'b0, r_power};
        sum_sat = sum[PW] ? '1 : sum[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata <= r_mem[r_idx[SC_IW-1:0]];
        end
        if (r_run && r_p_vld && (r_op == cbr_pkg::ACC_ADD)) begin
            r_mem[r_p_idx] <= sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_p_vld <= 1'b0;
            r_vld   <= '0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_op    <= cbr_pkg::ACC_CLEAR;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_run   <= 1'b1;
                r_op    <= i_ctl.op;
                r_idx   <= i_start_idx;
                r_end   <= i_end_idx;
                r_power <= i_power;
                r_cnt   <= '0;
                r_p_vld <= 1'b0;
            end else if (r_run) begin
                r_p_vld <= issue;
                r_p_idx <= r_idx[SC_IW-1:0];
                if (issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_p_vld) begin
                    if (r_op == cbr_pkg::ACC_ADD) begin
                        r_vld[r_p_idx] <= 1'b1;
                    end else if (cur > i_threshold) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                if (!issue && !r_p_vld) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                    // Counting a slot and discarding one both leave the
                    // accumulators empty.
                    if (r_op != cbr_pkg::ACC_ADD) begin
                        r_vld <= '0;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_busy = r_cnt;

endmodule
`default_nettype wire

>>> rtl/cbr_hist.sv
`default_nettype none
module cbr_hist #(
    parameter int MAX_WINDOW      = cbr_pkg::MAX_WINDOW_DEF,
    parameter int MAX_SUBCHANNELS = cbr_pkg::MAX_SUBCHANNELS_DEF
) (
    input  wire                                               i_clk,
    input  wire                                               i_rst_n,
    input  wire                                               i_start,
    input  wire [cbr_pkg::SLOT_W-1:0]                         i_slot,
    input  wire [$clog2(MAX_SUBCHANNELS+1)-1:0]               i_busy,
    input  wire [$clog2(MAX_WINDOW+1)-1:0]                    i_win,
    output logic                                              o_ready,
    output logic                                              o_done,
    output logic [$clog2(MAX_WINDOW*MAX_SUBCHANNELS+1)-1:0]   o_total
);

    localparam int CNT_W = $clog2(MAX_SUBCHANNELS + 1);
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int TOT_W = $clog2(MAX_WINDOW * MAX_SUBCHANNELS + 1);
    localparam int HW_CW = $clog2(MAX_WINDOW + 1);
    localparam int HW_IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW    = cbr_pkg::SLOT_W;
    // Entry layout from the lowest bit up: valid, busy count, slot tag.
    localparam int ENT_W = SW + CNT_W + 1;

    logic [ENT_W-1:0] r_mem [MAX_WINDOW];
    logic             r_clr;
    logic             r_run;
    logic [HW_CW-1:0] r_idx;
    logic             r_p_vld;
    logic [HW_IW-1:0] r_p_idx;
    logic [ENT_W-1:0] r_rdata;
    logic [HW_IW-1:0] r_wr;
    logic [TOT_W-1:0] r_tot;
    logic             r_done;
    logic [SW-1:0]    r_slot;
    logic [CNT_W-1:0] r_busy;
    logic [WIN_W-1:0] r_win;

    logic             issue;
    logic [SW-1:0]    rd_tag;
    logic [CNT_W-1:0] rd_cnt;
    logic             rd_vld;
    logic             is_new;
    logic             expired;
    logic [CNT_W-1:0] add_val;
    logic             wr_en;
    logic [HW_IW-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;

    always_comb begin
        issue   = r_run && (r_idx < HW_CW'(MAX_WINDOW));
        rd_vld  = r_rdata[0];
        rd_cnt  = r_rdata[CNT_W:1];
        rd_tag  = r_rdata[ENT_W-1:CNT_W+1];
        // The slot being closed lands in the ring at the write pointer.
        is_new  = (r_p_idx == r_wr);
        expired = ({1'b0, rd_tag} + (SW+1)'(r_win)) <= {1'b0, r_slot};
        add_val = '0;
        if (is_new) begin
            add_val = r_busy;
        end else if (rd_vld && !expired) begin
            add_val = rd_cnt;
        end
        wr_en   = 1'b0;
        wr_addr = r_p_idx;
        wr_data = {rd_tag, rd_cnt, 1'b0};
        if (r_clr) begin
            wr_en   = 1'b1;
            wr_addr = r_idx[HW_IW-1:0];
            wr_data = '0;
        end else if (r_run && r_p_vld) begin
            if (is_new) begin
                wr_en   = 1'b1;
                wr_data = {r_slot, r_busy, 1'b1};
            end else if (rd_vld && expired) begin
                wr_en = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata <= r_mem[r_idx[HW_IW-1:0]];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= 1'b1;
            r_run   <= 1'b0;
            r_idx   <= '0;
            r_p_vld <= 1'b0;
            r_wr    <= '0;
            r_done  <= 1'b0;
            r_tot   <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_clr) begin
                if (r_idx == HW_CW'(MAX_WINDOW - 1)) begin
                    r_clr <= 1'b0;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else if (i_start) begin
                r_run   <= 1'b1;
                r_idx   <= '0;
                r_p_vld <= 1'b0;
                r_tot   <= '0;
                r_slot  <= i_slot;
                r_busy  <= i_busy;
                r_win   <= i_win;
            end else if (r_run) begin
                r_p_vld <= issue;
                r_p_idx <= r_idx[HW_IW-1:0];
                if (issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_p_vld) begin
                    r_tot <= r_tot + TOT_W'(add_val);
                end
                if (!issue && !r_p_vld) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                    r_wr   <= (r_wr == HW_IW'(MAX_WINDOW - 1)) ? '0 : r_wr + 1'b1;
                end
            end
        end
    end

    assign o_ready = !r_clr;
    assign o_done  = r_done;
    assign o_total = r_tot;

endmodule
`default_nettype wire

>>> rtl/cbr_div.sv
`default_nettype none
module cbr_div #(
    parameter int MAX_WINDOW      = cbr_pkg::MAX_WINDOW_DEF,
    parameter int MAX_SUBCHANNELS = cbr_pkg::MAX_SUBCHANNELS_DEF
) (
    input  wire                                             i_clk,
    input  wire                                             i_rst_n,
    input  wire                                             i_start,
    input  wire [$clog2(MAX_WINDOW*MAX_SUBCHANNELS+1)-1:0]  i_total,
    input  wire [$clog2(MAX_WINDOW+1)-1:0]                  i_win,
    input  wire [$clog2(MAX_SUBCHANNELS+1)-1:0]             i_nsc,
    output logic                                            o_done,
    output logic [cbr_pkg::RATIO_W-1:0]                     o_ratio
);

    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int SC_CW = $clog2(MAX_SUBCHANNELS + 1);
    localparam int TOT_W = $clog2(MAX_WINDOW * MAX_SUBCHANNELS + 1);
    localparam int PW    = WIN_W + SC_CW;
    localparam int FW    = cbr_pkg::FRAC_W;
    localparam int RW    = cbr_pkg::RATIO_W;
    localparam int STEP_W = $clog2(FW + 1);

    logic              r_chk;
    logic              r_run;
    logic [STEP_W-1:0] r_step;
    logic [TOT_W-1:0]  r_rem;
    logic [TOT_W-1:0]  r_den;
    logic [FW-1:0]     r_q;
    logic [RW-1:0]     r_ratio;
    logic              r_done;

    logic [PW-1:0]    prod;
    logic [TOT_W:0]   rem2;
    logic             ge;
    logic [TOT_W:0]   diff;

    always_comb begin
        prod = PW'(i_win) * PW'(i_nsc);
        rem2 = {r_rem, 1'b0};
        ge   = rem2 >= {1'b0, r_den};
        diff = rem2 - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk  <= 1'b0;
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_chk <= 1'b1;
                r_rem <= i_total;
                r_den <= TOT_W'(prod);
            end else if (r_chk) begin
                r_chk <= 1'b0;
                // A total at or above the window size times the subchannel count is a full ratio.
                if (r_rem >= r_den) begin
                    r_ratio <= {1'b1, {FW{1'b0}}};
                    r_done  <= 1'b1;
                end else begin
                    r_run  <= 1'b1;
                    r_step <= STEP_W'(FW);
                    r_q    <= '0;
                end
            end else if (r_run) begin
                r_rem  <= ge ? diff[TOT_W-1:0] : rem2[TOT_W-1:0];
                r_q    <= {r_q[FW-2:0], ge};
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_run   <= 1'b0;
                    r_done  <= 1'b1;
                    r_ratio <= {1'b0, r_q[FW-2:0], ge};
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_ratio = r_ratio;

endmodule
`default_nettype wire

>>> rtl/channel_busy_ratio_meter.sv
// Channel busy ratio meter over a sliding window of slots.
// Input beats on s_*: tuser carries the command (add frame power, close a
// monitored slot, close an unmonitored slot); tdata carries the slot number,
// first subchannel, span and linear receive power. A monitored close yields
// one output beat on m_* with the busy count and the busy ratio in Q1.16;
// the other commands yield no beat.
// One command is worked at a time. A monitored close runs the history scan,
// which reads one ring entry per cycle through the single read port of its
// memory, and then the divider, whose bit loop is skipped when the ratio is
// full; the next beat can be accepted once the result is in the output
// register.
// The user must write the registers over the APB port only while the block is
// idle; the block itself does not enforce it. After reset the history memory
// is swept clear with s_tready low; register writes still work.
// The result sits in an output register, so s_tready comes back while a
// result waits; a further monitored close then holds at the output until
// m_tready takes the waiting beat.
`default_nettype none
module channel_busy_ratio_meter #(
    parameter int MAX_SUBCHANNELS = cbr_pkg::MAX_SUBCHANNELS_DEF,
    parameter int MAX_WINDOW      = cbr_pkg::MAX_WINDOW_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // slot_number[31:0], first_subchannel[36:32], span[42:37],
    // rx_power[74:43], zero[79:75]
    input  wire [cbr_pkg::S_DATA_W-1:0]       s_tdata,
    // func[1:0]
    input  wire [cbr_pkg::FUNC_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // busy_count[15:0], busy_ratio[32:16], zero[39:33]
    output logic [cbr_pkg::M_DATA_W-1:0]      m_tdata,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [cbr_pkg::ADDR_W-1:0]         paddr,
    input  wire [cbr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cbr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int SC_CW  = $clog2(MAX_SUBCHANNELS + 1);
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int TOT_W  = $clog2(MAX_WINDOW * MAX_SUBCHANNELS + 1);
    localparam int WCMP_W = (WIN_W > cbr_pkg::WIN_REG_W) ? WIN_W : cbr_pkg::WIN_REG_W;
    localparam int NCMP_W = (SC_CW > cbr_pkg::NSC_REG_W) ? SC_CW : cbr_pkg::NSC_REG_W;
    localparam int LCMP_W = (SC_CW > 7) ? SC_CW : 7;
    localparam int OCMP_W = (TOT_W > cbr_pkg::COUNT_OUT_W) ? TOT_W : cbr_pkg::COUNT_OUT_W;

    // Configuration registers.
    logic [cbr_pkg::WIN_REG_W-1:0] r_win_reg;
    logic [cbr_pkg::NSC_REG_W-1:0] r_nsc_reg;
    logic [cbr_pkg::THR_W-1:0]     r_thr;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_reg <= cbr_pkg::WIN_RESET;
            r_nsc_reg <= cbr_pkg::NSC_RESET;
            r_thr     <= cbr_pkg::THR_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                cbr_pkg::REG_WINDOW:    r_win_reg <= pwdata[cbr_pkg::WIN_REG_W-1:0];
                cbr_pkg::REG_SUBCH:     r_nsc_reg <= pwdata[cbr_pkg::NSC_REG_W-1:0];
                cbr_pkg::REG_THRESHOLD: r_thr     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            cbr_pkg::REG_WINDOW:    prdata = cbr_pkg::APB_DATA_W'(r_win_reg);
            cbr_pkg::REG_SUBCH:     prdata = cbr_pkg::APB_DATA_W'(r_nsc_reg);
            cbr_pkg::REG_THRESHOLD: prdata = r_thr;
            default:                prdata = '0;
        endcase
    end

    // Out-of-range register values are clamped into the supported range.
    logic [WIN_W-1:0] eff_win;
    logic [SC_CW-1:0] eff_nsc;

    always_comb begin
        if (r_win_reg == '0) begin
            eff_win = WIN_W'(1);
        end else if (WCMP_W'(r_win_reg) > WCMP_W'(MAX_WINDOW)) begin
            eff_win = WIN_W'(MAX_WINDOW);
        end else begin
            eff_win = WIN_W'(r_win_reg);
        end
        if (r_nsc_reg == '0) begin
            eff_nsc = SC_CW'(1);
        end else if (NCMP_W'(r_nsc_reg) > NCMP_W'(MAX_SUBCHANNELS)) begin
            eff_nsc = SC_CW'(MAX_SUBCHANNELS);
        end else begin
            eff_nsc = SC_CW'(r_nsc_reg);
        end
    end

    // Input beat fields.
    logic [cbr_pkg::FUNC_W-1:0]  in_func;
    logic [cbr_pkg::SLOT_W-1:0]  in_slot;
    logic [cbr_pkg::FIRST_W-1:0] in_first;
    logic [cbr_pkg::SPAN_W-1:0]  in_span;
    logic [cbr_pkg::POWER_W-1:0] in_power;
    logic [6:0]                  span_end;
    logic [LCMP_W-1:0]           last_c;
    logic [LCMP_W-1:0]           first_c;
    logic [SC_CW-1:0]            add_start;
    logic [SC_CW-1:0]            add_end;

    always_comb begin
        in_func  = s_tuser;
        in_slot  = s_tdata[31:0];
        in_first = s_tdata[36:32];
        in_span  = s_tdata[42:37];
        in_power = s_tdata[74:43];
        span_end = 7'(in_first) + 7'(in_span);
        last_c   = LCMP_W'(span_end);
        if (last_c > LCMP_W'(eff_nsc)) begin
            last_c = LCMP_W'(eff_nsc);
        end
        first_c  = LCMP_W'(in_first);
        // A frame starting past the clipped end covers nothing.
        if (first_c > last_c) begin
            first_c = last_c;
        end
        add_start = SC_CW'(first_c);
        add_end   = SC_CW'(last_c);
    end

    // Control sequencer.
    cbr_pkg::t_state   r_state;
    cbr_pkg::t_state   n_state;
    logic              r_close;
    logic [cbr_pkg::SLOT_W-1:0] r_slot;
    logic              in_fire;
    logic              out_load;
    logic              hist_start;
    logic              div_start;
    cbr_pkg::t_acc_ctl acc_ctl;
    logic [SC_CW-1:0]  acc_start_idx;
    logic [SC_CW-1:0]  acc_end_idx;
    logic              acc_done;
    logic [SC_CW-1:0]  acc_busy;
    logic              hist_ready;
    logic              hist_done;
    logic [TOT_W-1:0]  hist_total;
    logic              div_done;
    logic [cbr_pkg::RATIO_W-1:0] div_ratio;
    logic              r_out_valid;
    logic [cbr_pkg::M_DATA_W-1:0] r_out_data;

    assign in_fire = s_tvalid && s_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            cbr_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (in_func inside {cbr_pkg::FUNC_ADD, cbr_pkg::FUNC_CLOSE_MON,
                                        cbr_pkg::FUNC_CLOSE_UNMON}) begin
                        n_state = cbr_pkg::ST_ACC;
                    end
                end
            end
            cbr_pkg::ST_ACC: begin
                if (acc_done) begin
                    n_state = r_close ? cbr_pkg::ST_HIST : cbr_pkg::ST_IDLE;
                end
            end
            cbr_pkg::ST_HIST: begin
                if (hist_done) begin
                    n_state = cbr_pkg::ST_DIV;
                end
            end
            cbr_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = cbr_pkg::ST_OUT;
                end
            end
            cbr_pkg::ST_OUT: begin
                if (!r_out_valid || m_tready) begin
                    n_state = cbr_pkg::ST_IDLE;
                end
            end
            default: n_state = cbr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (r_state == cbr_pkg::ST_IDLE) && hist_ready;
        acc_ctl.start = 1'b0;
        acc_ctl.op    = cbr_pkg::ACC_ADD;
        acc_start_idx = add_start;
        acc_end_idx   = add_end;
        hist_start    = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            cbr_pkg::ST_IDLE: begin
                if (in_fire) begin
                    case (in_func)
                        cbr_pkg::FUNC_ADD: begin
                            acc_ctl.start = 1'b1;
                        end
                        cbr_pkg::FUNC_CLOSE_MON: begin
                            acc_ctl.start = 1'b1;
                            acc_ctl.op    = cbr_pkg::ACC_COUNT;
                            acc_start_idx = '0;
                            acc_end_idx   = eff_nsc;
                        end
                        cbr_pkg::FUNC_CLOSE_UNMON: begin
                            acc_ctl.start = 1'b1;
                            acc_ctl.op    = cbr_pkg::ACC_CLEAR;
                            acc_start_idx = '0;
                            acc_end_idx   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            cbr_pkg::ST_ACC:  hist_start = acc_done && r_close;
            cbr_pkg::ST_HIST: div_start  = hist_done;
            cbr_pkg::ST_OUT:  out_load   = !r_out_valid || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbr_pkg::ST_IDLE;
            r_close <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_close <= (in_func == cbr_pkg::FUNC_CLOSE_MON);
                r_slot  <= in_slot;
            end
        end
    end

    cbr_acc #(
        .MAX_SUBCHANNELS(MAX_SUBCHANNELS)
    ) u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (acc_ctl),
        .i_start_idx(acc_start_idx),
        .i_end_idx  (acc_end_idx),
        .i_power    (in_power),
        .i_threshold(r_thr),
        .o_done     (acc_done),
        .o_busy     (acc_busy)
    );

    cbr_hist #(
        .MAX_WINDOW     (MAX_WINDOW),
        .MAX_SUBCHANNELS(MAX_SUBCHANNELS)
    ) u_hist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(hist_start),
        .i_slot (r_slot),
        .i_busy (acc_busy),
        .i_win  (eff_win),
        .o_ready(hist_ready),
        .o_done (hist_done),
        .o_total(hist_total)
    );

    cbr_div #(
        .MAX_WINDOW     (MAX_WINDOW),
        .MAX_SUBCHANNELS(MAX_SUBCHANNELS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_total(hist_total),
        .i_win  (eff_win),
        .i_nsc  (eff_nsc),
        .o_done (div_done),
        .o_ratio(div_ratio)
    );

    // Output register; the busy count saturates at its field width.
    logic [cbr_pkg::COUNT_OUT_W-1:0] busy_sat;

    always_comb begin
        if (OCMP_W'(hist_total) > OCMP_W'({cbr_pkg::COUNT_OUT_W{1'b1}})) begin
            busy_sat = '1;
        end else begin
            busy_sat = cbr_pkg::COUNT_OUT_W'(hist_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= cbr_pkg::M_DATA_W'({div_ratio, busy_sat});
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule
`default_nettype wire
